@@ design/gnh_pkg.sv @@
// Package for the greedy geographic next-hop unit.
// Holds the beat types, status and kind codes, and register indexes.
// No dependencies.
package gnh_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned DIST_W  = 33;
	localparam int unsigned ADDR_W  = 3;

	localparam logic [2:0] STATUS_UPDATED  = 3'd0;
	localparam logic [2:0] STATUS_INSERTED = 3'd1;
	localparam logic [2:0] STATUS_FULL     = 3'd2;
	localparam logic [2:0] STATUS_FOUND    = 3'd3;
	localparam logic [2:0] STATUS_NONE     = 3'd4;

	localparam logic KIND_BEACON = 1'b0;
	localparam logic KIND_ROUTE  = 1'b1;

	localparam logic REG_OWN_X = 1'b0;
	localparam logic REG_OWN_Y = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COORD_W-1:0] hop_x;
		logic [COORD_W-1:0] hop_y;
		logic [DIST_W-1:0]  best_distance;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} entry_t;

	typedef struct packed {
		logic               valid;
		logic               own;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} tag_t;

endpackage

@@ design/gnh_table.sv @@
// Neighbor table memory: one write port, one read port, registered read data.
// Depends on gnh_pkg for the entry type.
module gnh_table #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IDX_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  gnh_pkg::entry_t   wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output gnh_pkg::entry_t   rd_data
);
	import gnh_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/gnh_dist.sv @@
// Three-stage squared-distance pipeline: differences, squares, sum.
// Depends on gnh_pkg for the tag type and widths.
module gnh_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gnh_pkg::tag_t               in_tag,
	input  logic [gnh_pkg::COORD_W-1:0] dest_x,
	input  logic [gnh_pkg::COORD_W-1:0] dest_y,
	output gnh_pkg::tag_t               out_tag,
	output logic [gnh_pkg::DIST_W-1:0]  out_dist,
	output logic                        pending
);
	import gnh_pkg::*;

	tag_t               tag_s2;
	tag_t               tag_s3;
	tag_t               tag_s4;
	logic [COORD_W-1:0] dx_s2;
	logic [COORD_W-1:0] dy_s2;
	logic [2*COORD_W-1:0] sqx_s3;
	logic [2*COORD_W-1:0] sqy_s3;
	logic [DIST_W-1:0]  dist_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= in_tag;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2   <= (in_tag.x > dest_x) ? in_tag.x - dest_x : dest_x - in_tag.x;
		dy_s2   <= (in_tag.y > dest_y) ? in_tag.y - dest_y : dest_y - in_tag.y;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		dist_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	assign out_tag  = tag_s4;
	assign out_dist = dist_s4;
	assign pending  = tag_s2.valid | tag_s3.valid | tag_s4.valid;

endmodule

@@ design/greedy_geographic_next_hop_unit.sv @@
// Greedy geographic next-hop unit: neighbor table with beacon insert and route lookup.
// Throughput: one item at a time; the table scan reads one entry per cycle from the memory.
// A new start is taken in the cycle done is shown; the receiver cannot stall.
// Reset clears the neighbor count and own position; table contents stay undefined.
// Depends on gnh_pkg, gnh_table and gnh_dist.
module greedy_geographic_next_hop_unit #(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  gnh_pkg::in_item_t          item,
	output logic                       done,
	output gnh_pkg::out_item_t         result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gnh_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import gnh_pkg::*;

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]         state_q;
	logic [COORD_W-1:0] own_x_q;
	logic [COORD_W-1:0] own_y_q;
	logic               kind_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   iss_q;
	logic [CNT_W-1:0]   count_q;
	logic               v_s1;
	logic               own_s1;
	logic               found_q;
	logic               chosen_q;
	logic [DIST_W-1:0]  best_q;
	logic [COORD_W-1:0] hx_q;
	logic [COORD_W-1:0] hy_q;
	logic               done_q;
	out_item_t          result_q;

	logic               accept;
	logic               cfg_wr;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             rd_data;
	logic               wr_en;
	entry_t             wr_data;
	tag_t               tag_s1;
	tag_t               tag_s4;
	logic [DIST_W-1:0]  dist_s4;
	logic               pending;
	logic               finish;
	logic               room;
	logic [CNT_W-1:0]   iss_m1;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_OWN_X: prdata = {16'd0, own_x_q};
			REG_OWN_Y: prdata = {16'd0, own_y_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q <= '0;
			own_y_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_OWN_X) begin
				own_x_q <= pwdata[COORD_W-1:0];
			end else begin
				own_y_q <= pwdata[COORD_W-1:0];
			end
		end
	end

	assign iss_m1  = iss_q - CNT_W'(1);
	assign rd_en   = (state_q == ST_SCAN) && (iss_q != '0);
	assign rd_addr = iss_m1[IDX_W-1:0];
	assign finish  = (state_q == ST_DRAIN) && !v_s1 && !pending;
	assign room    = (count_q < CNT_W'(TABLE_DEPTH));
	assign wr_en   = finish && (kind_q == KIND_BEACON) && !found_q && room;
	assign wr_data = '{x: cx_q, y: cy_q};

	gnh_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		tag_s1.valid = v_s1;
		tag_s1.own   = own_s1;
		tag_s1.x     = own_s1 ? own_x_q : rd_data.x;
		tag_s1.y     = own_s1 ? own_y_q : rd_data.y;
	end

	gnh_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (tag_s1),
		.dest_x   (cx_q),
		.dest_y   (cy_q),
		.out_tag  (tag_s4),
		.out_dist (dist_s4),
		.pending  (pending)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= '0;
			n_q     <= '0;
			count_q <= '0;
			v_s1    <= 1'b0;
			own_s1  <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			v_s1   <= (state_q == ST_SCAN);
			own_s1 <= (state_q == ST_SCAN) && (iss_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						iss_q   <= '0;
						n_q     <= count_q;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					iss_q  <= iss_q + CNT_W'(1);
					if (iss_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (wr_en) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_s1 && !own_s1 && rd_data.x == cx_q && rd_data.y == cy_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= item.kind;
			cx_q   <= item.coord_x;
			cy_q   <= item.coord_y;
		end
		if (tag_s4.valid) begin
			if (tag_s4.own) begin
				best_q   <= dist_s4;
				hx_q     <= tag_s4.x;
				hy_q     <= tag_s4.y;
				chosen_q <= 1'b0;
			end else if (dist_s4 < best_q) begin
				best_q   <= dist_s4;
				hx_q     <= tag_s4.x;
				hy_q     <= tag_s4.y;
				chosen_q <= 1'b1;
			end
		end
		if (finish) begin
			if (kind_q == KIND_BEACON) begin
				result_q.hop_x         <= '0;
				result_q.hop_y         <= '0;
				result_q.best_distance <= '0;
				if (found_q) begin
					result_q.status <= STATUS_UPDATED;
				end else if (room) begin
					result_q.status <= STATUS_INSERTED;
				end else begin
					result_q.status <= STATUS_FULL;
				end
			end else begin
				result_q.status        <= chosen_q ? STATUS_FOUND : STATUS_NONE;
				result_q.hop_x         <= hx_q;
				result_q.hop_y         <= hy_q;
				result_q.best_distance <= best_q;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/gnh_checker.sv @@
// Port-level checker for the greedy geographic next-hop unit, bound to the top level.
// Depends on gnh_pkg for the beat types and status codes.
module gnh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input gnh_pkg::out_item_t result
);
	import gnh_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Block did not go busy after an accepted beat.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result shown while still busy.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Two results in consecutive cycles.");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == STATUS_UPDATED || result.status == STATUS_INSERTED ||
			result.status == STATUS_FULL || result.status == STATUS_FOUND ||
			result.status == STATUS_NONE))
		else $error("Illegal status code.");

	a_beacon_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == STATUS_UPDATED || result.status == STATUS_INSERTED ||
			result.status == STATUS_FULL) |->
			result.hop_x == '0 && result.hop_y == '0 && result.best_distance == '0)
		else $error("Beacon result carries nonzero hop fields.");

endmodule

bind greedy_geographic_next_hop_unit gnh_checker u_gnh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ tb/testbench.sv @@
// Self-checking testbench for greedy_geographic_next_hop_unit.
// Drives beacon and route beats, writes the own position over APB and checks every result.
// Depends on gnh_pkg and the unit under test.
`timescale 1ns / 100ps

module testbench;
	import gnh_pkg::*;

	localparam int unsigned TABLE_DEPTH = 32;
	localparam int unsigned STALL_LIMIT = 2000;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                start    = 1'b0;
	logic                busy;
	in_item_t            item     = '0;
	logic                done;
	out_item_t           result_beat;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ADDR_W-1:0]   paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	in_item_t            pending[$];
	out_item_t           route_results[$];
	entry_t              known[$];
	out_item_t           want;
	logic [COORD_W-1:0]  nbr_x[TABLE_DEPTH];
	logic [COORD_W-1:0]  nbr_y[TABLE_DEPTH];
	int unsigned         nbr_count = 0;
	logic [COORD_W-1:0]  my_x = '0;
	logic [COORD_W-1:0]  my_y = '0;
	logic                item_taken = 1'b0;
	bit                  no_gaps = 1'b0;
	int                  gap_left = 0;
	int unsigned         idle_cycles = 0;
	int unsigned         errors = 0;

	greedy_geographic_next_hop_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result_beat),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic logic [DIST_W-1:0] sq_distance(logic [COORD_W-1:0] ax,
			logic [COORD_W-1:0] ay, logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
		logic [DIST_W-1:0] dx;
		logic [DIST_W-1:0] dy;
		dx = (ax > bx) ? DIST_W'(ax - bx) : DIST_W'(bx - ax);
		dy = (ay > by) ? DIST_W'(ay - by) : DIST_W'(by - ay);
		return dx * dx + dy * dy;
	endfunction

	function automatic out_item_t learn_or_route(in_item_t it);
		out_item_t r;
		logic [DIST_W-1:0] d;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (it.kind == KIND_BEACON) begin
			for (int i = 0; i < nbr_count; i++) begin
				if (nbr_x[i] == it.coord_x && nbr_y[i] == it.coord_y) begin
					hit = 1'b1;
				end
			end
			if (hit) begin
				r.status = STATUS_UPDATED;
			end else if (nbr_count < TABLE_DEPTH) begin
				nbr_x[nbr_count] = it.coord_x;
				nbr_y[nbr_count] = it.coord_y;
				nbr_count++;
				r.status = STATUS_INSERTED;
			end else begin
				r.status = STATUS_FULL;
			end
		end else begin
			r.status = STATUS_NONE;
			r.hop_x = my_x;
			r.hop_y = my_y;
			r.best_distance = sq_distance(my_x, my_y, it.coord_x, it.coord_y);
			for (int i = 0; i < nbr_count; i++) begin
				d = sq_distance(nbr_x[i], nbr_y[i], it.coord_x, it.coord_y);
				if (d < r.best_distance) begin
					r.status = STATUS_FOUND;
					r.hop_x = nbr_x[i];
					r.hop_y = nbr_y[i];
					r.best_distance = d;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom_range(0, 15));
			1: return 16'hFFFF - COORD_W'($urandom_range(0, 15));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 60);
	endfunction

	task automatic plan_item(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		in_item_t it;
		entry_t spot;
		bit fresh;
		it.kind = kind;
		it.coord_x = x;
		it.coord_y = y;
		spot.x = x;
		spot.y = y;
		fresh = 1'b1;
		foreach (known[i]) begin
			if (known[i] == spot) begin
				fresh = 1'b0;
			end
		end
		if (kind == KIND_BEACON && fresh && known.size() < TABLE_DEPTH) begin
			known.insert(known.size(), spot);
		end
		pending.insert(pending.size(), it);
	endtask

	// Half of the beats reuse a stored neighbor, so refreshes and near-neighbor routes are common.
	task automatic plan_random();
		entry_t spot;
		bit reuse;
		reuse = (known.size() != 0) && ($urandom_range(0, 1) == 1);
		if (reuse) begin
			spot = known[$urandom_range(0, known.size() - 1)];
		end else begin
			spot.x = pick_coord();
			spot.y = pick_coord();
		end
		if ($urandom_range(0, 99) < 45) begin
			plan_item(KIND_BEACON, spot.x, spot.y);
		end else begin
			if (reuse && $urandom_range(0, 1) == 1) begin
				spot.x = spot.x + COORD_W'($urandom_range(0, 6)) - 16'd3;
				spot.y = spot.y + COORD_W'($urandom_range(0, 6)) - 16'd3;
			end
			plan_item(KIND_ROUTE, spot.x, spot.y);
		end
	endtask

	task automatic reg_write(logic idx, logic [COORD_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= {16'h0000, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (idx == REG_OWN_X) begin
			my_x = value;
		end else begin
			my_y = value;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (pending.size() != 0 || start || route_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !item_taken) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() != 0) begin
				item <= pending.pop_front();
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (done) begin
				if (route_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = route_results.pop_front();
					if (result_beat.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_beat.status);
						errors++;
					end
					if (result_beat.hop_x !== want.hop_x) begin
						$error("hop_x: expected %0d, got %0d", want.hop_x, result_beat.hop_x);
						errors++;
					end
					if (result_beat.hop_y !== want.hop_y) begin
						$error("hop_y: expected %0d, got %0d", want.hop_y, result_beat.hop_y);
						errors++;
					end
					if (result_beat.best_distance !== want.best_distance) begin
						$error("best_distance: expected %0d, got %0d", want.best_distance,
							result_beat.best_distance);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				route_results.insert(route_results.size(), learn_or_route(item));
			end
			item_taken <= start && !busy;
			if (done || (start && !busy)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan_item(KIND_ROUTE, 16'd100, 16'd100);
		plan_item(KIND_ROUTE, 16'd0, 16'd0);
		plan_item(KIND_BEACON, 16'd0, 16'd0);
		plan_item(KIND_BEACON, 16'd10, 16'd0);
		plan_item(KIND_BEACON, 16'd0, 16'd10);
		plan_item(KIND_BEACON, 16'd10, 16'd0);
		plan_item(KIND_ROUTE, 16'd6, 16'd6);
		plan_item(KIND_ROUTE, 16'd0, 16'd0);
		plan_item(KIND_ROUTE, 16'd5, 16'd5);
		plan_item(KIND_BEACON, 16'hFFFF, 16'hFFFF);
		plan_item(KIND_BEACON, 16'hFFFF, 16'd0);
		plan_item(KIND_BEACON, 16'd0, 16'hFFFF);
		plan_item(KIND_ROUTE, 16'hFFFF, 16'hFFFF);
		plan_item(KIND_ROUTE, 16'hFFFF, 16'd0);
		plan_item(KIND_ROUTE, 16'h8000, 16'h8000);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			reg_write(REG_OWN_X, (p == 0 || p == 2) ? 16'hFFFF :
				(p == 1 || p == 5) ? 16'h0000 : pick_coord());
			reg_write(REG_OWN_Y, (p == 0 || p == 1) ? 16'hFFFF :
				(p == 2 || p == 5) ? 16'h0000 : pick_coord());
			no_gaps = (p == 3);
			plan_item(KIND_ROUTE, 16'd0, 16'd0);
			plan_item(KIND_ROUTE, 16'hFFFF, 16'hFFFF);
			repeat (170) plan_random();
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

@@ greedy_geographic_next_hop_unit.f @@
design/gnh_pkg.sv
design/gnh_table.sv
design/gnh_dist.sv
design/greedy_geographic_next_hop_unit.sv
design/gnh_checker.sv
tb/testbench.sv
